[src/assert_macros.svh]
// Assertion helpers shared by the transcoder modules.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define U8U16_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define U8U16_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/u8u16_pkg.sv]
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] QMARK_UNIT   = 16'h003F;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // One complete run of bytes to be decoded: up to four bytes, oldest in
  // byte 0, the number of valid bytes, and whether the string ends here.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
  } job_t;

  // Sequence length announced by a lead byte; zero means undecodable.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [4:0] top;
    top = b[7:3];
    if (top < 5'd16) begin
      return 3'd1;
    end else if (top < 5'd24) begin
      return 3'd0;
    end else if (top < 5'd28) begin
      return 3'd2;
    end else if (top < 5'd30) begin
      return 3'd3;
    end else if (top == 5'd30) begin
      return 3'd4;
    end else begin
      return 3'd0;
    end
  endfunction

endpackage

[src/u8u16_byte_if.sv]
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

[src/u8u16_unit_if.sv]
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        string_done;

  modport source (output valid, output code_unit, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input code_unit, input run_last, input string_done,
                  output ready);
endinterface

[src/utf8_to_utf16_transcoder_unit.sv]
// UTF-8 to UTF-16 transcoder.
// byte_in carries one UTF-8 byte per transfer, with end_of_string set on the
// final byte of a string. unit_out carries one UTF-16 code unit per transfer;
// run_last marks the last unit caused by one input byte and string_done the
// final unit of the string. Bytes that only extend an open sequence produce no
// unit. Undecodable bytes produce 0x003F, and a string that ends mid-sequence
// is rescanned byte by byte.
// Throughput: one byte per cycle in while the run queue has room, and one
// code unit per cycle out while unit_out is ready; a byte that completes a
// run holds the decoder until each of its units has gone out. With the
// decoder idle, the run of a completing byte enters the queue at the
// transfer edge, is then loaded as the working run and then reaches the
// output register, from which its first unit is valid on unit_out.
// A four-entry run queue sits between the byte front end and the decoder, so
// a stall on unit_out first fills the queue and only then drops byte_in.ready.
// Synchronous reset (rst high) empties the sequence buffer, the queue and the
// output register; byte_in.ready is high again in the cycle after reset.
module utf8_to_utf16_transcoder_unit (
  input  logic          clk,
  input  logic          rst,
  u8u16_byte_if.sink    byte_in,
  u8u16_unit_if.source  unit_out
);
  import u8u16_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  // Front end: buffers bytes of an open sequence and hands over complete runs.
  u8u16_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_full  (q_full),
    .push    (push),
    .job     (push_job)
  );

  // Short queue decoupling byte intake from unit output.
  u8u16_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (push_job),
    .pop       (pop),
    .rd_job    (head_job),
    .not_empty (head_valid),
    .full      (q_full)
  );

  // Back end: decodes each run into code units, one per cycle unless stalled.
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .unit_out   (unit_out)
  );

endmodule

[src/u8u16_front.sv]
`include "assert_macros.svh"

module u8u16_front (
  input  logic              clk,
  input  logic              rst,
  u8u16_byte_if.sink        byte_in,
  input  logic              q_full,
  output logic              push,
  output u8u16_pkg::job_t   job
);
  import u8u16_pkg::*;

  logic [7:0] held_bytes [3];
  logic [1:0] held_count;
  logic [2:0] expected_length;

  logic       accept;
  logic       flush;
  logic [2:0] n;
  logic [2:0] l_in;

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;

  always_comb begin
    n    = {1'b0, held_count} + 3'd1;
    l_in = seq_len(byte_in.data_byte);
    if (byte_in.end_of_string) begin
      flush = 1'b1;
    end else if (expected_length == 3'd0) begin
      flush = (l_in < 3'd2);
    end else begin
      flush = (n >= expected_length);
    end
  end

  // Held bytes first, the incoming byte after them.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      job.bytes[k] = (2'(k) < held_count) ? held_bytes[k] : byte_in.data_byte;
    end
    job.bytes[3] = byte_in.data_byte;
    job.count    = n;
    job.last     = byte_in.end_of_string;
  end

  assign push = accept && flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= 3'd0;
    end else if (accept) begin
      if (flush) begin
        held_count      <= 2'd0;
        expected_length <= 3'd0;
      end else begin
        if (expected_length == 3'd0) begin
          expected_length <= l_in;
        end
        if (held_count != 2'd3) begin
          held_count <= held_count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !flush && held_count != 2'd3) begin
      held_bytes[held_count] <= byte_in.data_byte;
    end
  end

  `U8U16_ASSERT_IMP(a_open_seq_short, expected_length != 3'd0,
    held_count != 2'd0 && 3'(held_count) < expected_length,
    "open sequence holds too many bytes")
  `U8U16_ASSERT_IMP(a_idle_empty, expected_length == 3'd0, held_count == 2'd0,
    "bytes held with no open sequence")

endmodule

[src/u8u16_queue.sv]
`include "assert_macros.svh"

module u8u16_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8u16_pkg::job_t   wr_job,
  input  logic              pop,
  output u8u16_pkg::job_t   rd_job,
  output logic              not_empty,
  output logic              full
);
  import u8u16_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rd_job    = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  `U8U16_ASSERT_IMP(a_q_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `U8U16_ASSERT_IMP(a_q_pop_nonempty, pop, count != '0, "pop from an empty queue")

endmodule

[src/u8u16_back.sv]
`include "assert_macros.svh"

module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  u8u16_pkg::job_t   head,
  input  logic              head_valid,
  output logic              pop,
  u8u16_unit_if.source      unit_out
);
  import u8u16_pkg::*;

  // Working run: bytes still to decode sit from byte 0 upwards.
  logic            w_valid;
  logic [3:0][7:0] w_bytes;
  logic [2:0]      w_left;
  logic [1:0]      w_cnt;
  logic            w_end;
  logic            lo_pending;
  logic [9:0]      lo_bits;

  // Output register.
  logic        o_valid;
  logic [15:0] o_unit;
  logic        o_last;
  logic        o_done;

  logic        adv;
  logic        fire;
  logic [2:0]  l;
  logic        bad;
  logic [20:0] cp;
  logic [20:0] c;
  logic [15:0] unit;
  logic [2:0]  used;
  logic        is_hi;
  logic [2:0]  left_after;
  logic [1:0]  cnt_after;
  logic        last;

  always_comb begin
    l   = seq_len(w_bytes[0]);
    bad = (l == 3'd0) || (l > w_left);
    case (l)
      3'd1:    cp = {14'd0, w_bytes[0][6:0]};
      3'd2:    cp = {10'd0, w_bytes[0][4:0], w_bytes[1][5:0]};
      3'd3:    cp = {5'd0, w_bytes[0][3:0], w_bytes[1][5:0], w_bytes[2][5:0]};
      3'd4:    cp = {w_bytes[0][2:0], w_bytes[1][5:0], w_bytes[2][5:0], w_bytes[3][5:0]};
      default: cp = '0;
    endcase
    c = cp - SUPP_BASE;

    is_hi = 1'b0;
    if (lo_pending) begin
      unit = SURR_LO_BASE + {6'd0, lo_bits};
      used = 3'd0;
    end else if (bad) begin
      unit = QMARK_UNIT;
      used = 3'd1;
    end else if (cp < SUPP_BASE) begin
      unit = cp[15:0];
      used = l;
    end else begin
      unit  = SURR_HI_BASE + {5'd0, c[20:10]};
      used  = l;
      is_hi = 1'b1;
    end

    left_after = w_left - used;
    cnt_after  = w_cnt + 2'd1;
    // A run ends when its bytes are used up or three units have gone out.
    last = !is_hi && ((left_after == 3'd0) || (cnt_after == 2'd3));
  end

  assign adv  = !o_valid || unit_out.ready;
  assign fire = w_valid && adv;
  assign pop  = head_valid && (!w_valid || (fire && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      w_valid    <= 1'b0;
      lo_pending <= 1'b0;
    end else begin
      if (adv) begin
        o_valid <= fire;
      end
      if (pop) begin
        w_valid    <= 1'b1;
        lo_pending <= 1'b0;
      end else if (fire && last) begin
        w_valid    <= 1'b0;
        lo_pending <= 1'b0;
      end else if (fire) begin
        lo_pending <= is_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_unit <= unit;
      o_last <= last;
      o_done <= last && w_end;
    end
    if (pop) begin
      w_bytes <= head.bytes;
      w_left  <= head.count;
      w_cnt   <= 2'd0;
      w_end   <= head.last;
    end else if (fire) begin
      w_bytes <= w_bytes >> {used, 3'b000};
      w_left  <= left_after;
      w_cnt   <= cnt_after;
      lo_bits <= c[9:0];
    end
  end

  assign unit_out.valid       = o_valid;
  assign unit_out.code_unit   = o_unit;
  assign unit_out.run_last    = o_last;
  assign unit_out.string_done = o_done;

  `U8U16_ASSERT_IMP(a_done_is_last, o_valid && o_done, o_last,
    "string end flagged on a unit that does not close its run")
  `U8U16_ASSERT_NXT(a_hi_then_lo, fire && is_hi, lo_pending && w_valid,
    "high surrogate not followed by its low half")

endmodule

[tb/u8u16_check_pkg.sv]
package u8u16_check_pkg;

  import u8u16_pkg::QMARK_UNIT;
  import u8u16_pkg::SURR_HI_BASE;
  import u8u16_pkg::SURR_LO_BASE;
  import u8u16_pkg::SUPP_BASE;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_done;
  } utf16_unit_t;

  // Tracks the decoder's sequence buffer and keeps the code units that the
  // block still owes, oldest first.
  class utf16_unit_tracker;
    utf16_unit_t owed_units[$];
    logic [7:0]  held[3];
    int unsigned held_count;
    int unsigned open_len;
    int unsigned errors;

    function new();
      held_count = 0;
      open_len   = 0;
      errors     = 0;
    endfunction

    // Length of the sequence that a lead byte opens; zero if it opens none.
    function int unsigned lead_length(logic [7:0] b);
      casez (b[7:3])
        5'b0????: return 1;
        5'b10???: return 0;
        5'b110??: return 2;
        5'b1110?: return 3;
        5'b11110: return 4;
        default:  return 0;
      endcase
    endfunction

    // Decodes a complete run of bytes, at most three units being produced.
    function void decode_run(logic [7:0] run[4], int unsigned n, logic eos);
      logic [15:0] units[$];
      int unsigned i;
      int unsigned len;
      logic [20:0] cp;
      logic [20:0] offset;
      logic        tail;
      i = 0;
      while (i < n && units.size() < 3) begin
        len = lead_length(run[i]);
        if (len == 0 || len > n - i) begin
          units.push_back(QMARK_UNIT);
          i++;
        end else begin
          case (len)
            1: cp = {14'd0, run[i][6:0]};
            2: cp = {10'd0, run[i][4:0], run[i+1][5:0]};
            3: cp = {5'd0, run[i][3:0], run[i+1][5:0], run[i+2][5:0]};
            default: cp = {run[i][2:0], run[i+1][5:0], run[i+2][5:0], run[i+3][5:0]};
          endcase
          if (cp < SUPP_BASE) begin
            units.push_back(cp[15:0]);
          end else begin
            offset = cp - SUPP_BASE;
            units.push_back(SURR_HI_BASE + {5'd0, offset[20:10]});
            units.push_back(SURR_LO_BASE + {6'd0, offset[9:0]});
          end
          i += len;
        end
      end
      foreach (units[k]) begin
        tail = (k == units.size() - 1);
        owed_units.push_back('{code_unit: units[k], run_last: tail,
                               string_done: tail && eos});
      end
    endfunction

    // Called for every byte transfer into the block.
    function void note_byte(logic [7:0] b, logic eos);
      logic [7:0]  run[4];
      int unsigned n;
      int unsigned len;
      bit          flush;
      foreach (run[k]) run[k] = 8'h00;
      for (int k = 0; k < held_count; k++) run[k] = held[k];
      run[held_count] = b;
      n = held_count + 1;
      if (eos) begin
        flush = 1'b1;
      end else if (open_len == 0) begin
        len   = lead_length(b);
        flush = (len < 2);
        if (!flush) open_len = len;
      end else begin
        flush = (n >= open_len || n >= 4);
      end
      if (!flush) begin
        if (held_count < 3) begin
          held[held_count] = b;
          held_count++;
        end
        return;
      end
      decode_run(run, n, eos);
      held_count = 0;
      open_len   = 0;
    endfunction

    // Called for every code unit transfer out of the block.
    function void check_unit(logic [15:0] code_unit, logic run_last, logic string_done);
      utf16_unit_t want;
      if (owed_units.size() == 0) begin
        $error("code unit %h arrived with none outstanding", code_unit);
        errors++;
        return;
      end
      want = owed_units.pop_front();
      if (code_unit !== want.code_unit) begin
        $error("code_unit: expected %h, actual %h", want.code_unit, code_unit);
        errors++;
      end
      if (run_last !== want.run_last) begin
        $error("run_last: expected %b, actual %b", want.run_last, run_last);
        errors++;
      end
      if (string_done !== want.string_done) begin
        $error("string_done: expected %b, actual %b", want.string_done, string_done);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u8u16_check_pkg::*;

  // Cycles without any transfer on either side before the run is abandoned.
  // The longest legitimate quiet spell is the deliberate receiver hold-off.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SINK_HOLD_CYCLES = 60;
  localparam int unsigned RANDOM_BYTES = 500;

  // Kinds of element that the random strings are built from.
  typedef enum {SEQ_ASCII, SEQ_STRAY, SEQ_TWO, SEQ_THREE, SEQ_FOUR} seq_kind_t;

  logic clk = 1'b0;
  logic rst;

  u8u16_byte_if byte_ch();
  u8u16_unit_if unit_ch();

  utf16_unit_tracker tracker;

  // Shared between the sender and the receiver: idling is switched off for
  // one long stretch of the run, and the sender asks for one long hold-off.
  bit          idle_on = 1'b1;
  bit          sink_hold_req = 1'b0;
  int unsigned sent = 0;
  int unsigned stalled = 0;

  utf8_to_utf16_transcoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .unit_out (unit_ch)
  );

  always #6 clk = ~clk;

  // Offers one byte and waits for its transfer. Before offering it, the
  // sender may idle for a few cycles with valid low. The byte is passed to
  // the tracker at the edge where the transfer happens; the block cannot
  // produce a unit for it in that same cycle.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_on && $urandom_range(99) < 15) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_string <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    tracker.note_byte(b, last);
    sent++;
  endtask

  // Receiver. Transfers are sampled straight after the edge, before any
  // register in the block has updated, and ready for the next cycle is then
  // chosen. A requested hold-off keeps ready low for a counted stretch so
  // that the run queue fills and the block drops ready on its input.
  initial begin : unit_receiver
    int unsigned hold_left;
    hold_left = 0;
    unit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && unit_ch.valid && unit_ch.ready) begin
        tracker.check_unit(unit_ch.code_unit, unit_ch.run_last, unit_ch.string_done);
      end
      if (sink_hold_req) begin
        hold_left     = SINK_HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        unit_ch.ready <= 1'b0;
      end else begin
        unit_ch.ready <= !(idle_on && $urandom_range(99) < 15);
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
      stalled = 0;
    end else begin
      stalled++;
      if (stalled >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    // Directed bytes, end-of-string flag in bit 8. They cover the edges of
    // ASCII, a two-byte form, the largest four-byte code point that the
    // length field allows, stray continuation and 11111 leads, an encoded
    // surrogate, an overlong form, a multi-byte lead as the final byte, and
    // a string that ends inside a four-byte sequence so that the rescan
    // gives three units.
    logic [8:0]  directed[$] = '{
      9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0F0, 9'h09F, 9'h098, 9'h080,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0ED, 9'h0A0,
      9'h080, 9'h0C0, 9'h080, 9'h1E2, 9'h0F0, 9'h09F, 9'h141
    };
    logic [7:0]  text[$];
    seq_kind_t   kind;
    int unsigned n_seq;
    int unsigned len;
    int unsigned pick;
    bit          did_hold;
    bit          did_drain;

    tracker   = new();
    did_hold  = 1'b0;
    did_drain = 1'b0;
    rst                   <= 1'b1;
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= 8'h00;
    byte_ch.end_of_string <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_byte(directed[k][7:0], directed[k][8]);

    // Random strings: mostly well-formed sequences with random payload bits,
    // some stray bytes, continuations that are occasionally arbitrary bytes,
    // and now and then a string cut off inside a sequence.
    while (sent < RANDOM_BYTES + directed.size()) begin
      text.delete();
      n_seq = $urandom_range(1, 10);
      repeat (n_seq) begin
        pick = $urandom_range(99);
        if (pick < 30)      kind = SEQ_ASCII;
        else if (pick < 40) kind = SEQ_STRAY;
        else if (pick < 60) kind = SEQ_TWO;
        else if (pick < 80) kind = SEQ_THREE;
        else                kind = SEQ_FOUR;
        case (kind)
          SEQ_ASCII: begin
            text.push_back(8'($urandom_range(127)));
          end
          SEQ_STRAY: begin
            if ($urandom_range(1) == 0) text.push_back(8'h80 | 8'($urandom_range(63)));
            else text.push_back(8'hF8 | 8'($urandom_range(7)));
          end
          default: begin
            len = (kind == SEQ_TWO) ? 2 : (kind == SEQ_THREE) ? 3 : 4;
            if (len == 2)      text.push_back(8'hC0 | 8'($urandom_range(31)));
            else if (len == 3) text.push_back(8'hE0 | 8'($urandom_range(15)));
            else               text.push_back(8'hF0 | 8'($urandom_range(7)));
            repeat (len - 1) begin
              if ($urandom_range(9) == 0) text.push_back(8'($urandom_range(255)));
              else text.push_back(8'h80 | 8'($urandom_range(63)));
            end
          end
        endcase
      end
      // Occasionally the string stops part-way through a multi-byte sequence.
      if ($urandom_range(6) == 0) begin
        len = $urandom_range(2, 4);
        if (len == 2)      text.push_back(8'hC0 | 8'($urandom_range(31)));
        else if (len == 3) text.push_back(8'hE0 | 8'($urandom_range(15)));
        else               text.push_back(8'hF0 | 8'($urandom_range(7)));
        repeat ($urandom_range(0, len - 2)) text.push_back(8'h80 | 8'($urandom_range(63)));
      end

      // One long receiver hold-off while the sender keeps offering bytes.
      if (!did_hold && sent >= 150) begin
        sink_hold_req = 1'b1;
        did_hold      = 1'b1;
      end
      // One pause of the sender until every owed unit has been transferred.
      if (!did_drain && sent >= 350) begin
        byte_ch.valid <= 1'b0;
        while (tracker.owed_units.size() != 0) @(posedge clk);
        did_drain = 1'b1;
      end
      // A long stretch with no idling on either side.
      idle_on = !(sent >= 240 && sent < 330);

      foreach (text[k]) send_byte(text[k], k == text.size() - 1);
    end
    byte_ch.valid <= 1'b0;

    // Let every owed unit arrive, then watch a little longer for strays.
    while (tracker.owed_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (tracker.errors == 0 && tracker.owed_units.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
